[rtl/uvas_pkg.sv]
// Shared types, constants and register indexes for the UV sensor auto-range scaler.
// No dependencies; every other file depends on this package.
package uvas_pkg;

	localparam int GAIN_CODES = 12;
	localparam int TIME_CODES = 8;
	localparam int GAIN_W     = 4;
	localparam int TIME_W     = 3;
	localparam int COUNT_W    = 16;
	localparam int COEF_W     = 24;
	localparam int PROD_W     = COUNT_W + COEF_W;
	localparam int IRR_W      = 40;
	localparam int UVI_W      = 47;
	localparam int CTRL_W     = 8;
	localparam int SHIFT_W    = $clog2(GAIN_CODES + TIME_CODES - 1);
	localparam int SUM_W      = 52;
	localparam int DVD_W      = 56;
	localparam int DIV_BITS   = 8;
	localparam int DIV_ROUNDS = DVD_W / DIV_BITS;
	localparam int RND_W      = $clog2(DIV_ROUNDS);
	localparam int REM_W      = 7;
	localparam int DIVISOR    = 100;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(GAIN_CODES - 1);
	localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'(TIME_CODES - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHT_LIMIT = 3'd0,
		REG_DARK_LIMIT   = 3'd1,
		REG_START_GAIN   = 3'd2,
		REG_START_TIME   = 3'd3,
		REG_COEF_A       = 3'd4,
		REG_COEF_B       = 3'd5,
		REG_COEF_C       = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               mul_en;
		logic [SHIFT_W-1:0] shift;
	} scale_ctl_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

[rtl/uvas_if.sv]
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on uvas_pkg for field widths.
interface uvas_in_if;
	logic                          valid;
	logic                          ready;
	logic [uvas_pkg::COUNT_W-1:0]  count_a;
	logic [uvas_pkg::COUNT_W-1:0]  count_b;
	logic [uvas_pkg::COUNT_W-1:0]  count_c;

	modport source (output valid, count_a, count_b, count_c, input ready);
	modport sink   (input valid, count_a, count_b, count_c, output ready);
endinterface

interface uvas_out_if;
	logic                          valid;
	logic                          ready;
	logic [uvas_pkg::IRR_W-1:0]    irr_a;
	logic [uvas_pkg::IRR_W-1:0]    irr_b;
	logic [uvas_pkg::IRR_W-1:0]    irr_c;
	logic [uvas_pkg::UVI_W-1:0]    uv_level;
	logic [uvas_pkg::GAIN_W-1:0]   next_gain;
	logic [uvas_pkg::TIME_W-1:0]   next_time;
	logic                          setting_changed;
	logic [uvas_pkg::CTRL_W-1:0]   control_byte;

	modport source (output valid, irr_a, irr_b, irr_c, uv_level, next_gain, next_time,
		setting_changed, control_byte, input ready);
	modport sink   (input valid, irr_a, irr_b, irr_c, uv_level, next_gain, next_time,
		setting_changed, control_byte, output ready);
endinterface

[rtl/uv_sensor_autorange_scaler_core.sv]
// Top level of the UV sensor auto-range scaler: sequencer, range control, registers.
// Depends on uvas_pkg, uvas_if, uvas_scale_unit and uvas_div100.
//
// A sample transfer runs from acceptance through ST_MUL, ST_SUM, ST_DIV and ST_DONE before
// the next ready, so no new sample is taken until the last result is loaded: the shared
// multiplier serves the three channels in turn (the product is registered before shift
// and saturation), the UV index sum starts the divide by one hundred at eight bits a cycle,
// the quotient is collected and the output register loaded. The load waits for as long as
// the previous result sits in the output register untaken. Input ready is high only while
// the sequencer is idle; the result stays in its output register until taken, and a new
// sample may be accepted meanwhile. Gain and time codes used for scaling are those in force
// before the adjustment that the same sample causes; a write to start_gain or start_time
// reloads the corresponding code.
module uv_sensor_autorange_scaler_core (
	input  logic                            clk,
	input  logic                            arst_n,
	uvas_in_if.sink                         samples,
	uvas_out_if.source                      results,
	input  logic                            cfg_wr_en,
	input  logic [uvas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uvas_pkg::CFG_DATA_W-1:0] cfg_data
);
	import uvas_pkg::*;

	state_t             state_q;
	state_t             state_nx;
	logic [1:0]         ch_q;

	logic [COUNT_W-1:0] bright_q;
	logic [COUNT_W-1:0] dark_q;
	logic [COEF_W-1:0]  coef_a_q;
	logic [COEF_W-1:0]  coef_b_q;
	logic [COEF_W-1:0]  coef_c_q;
	logic [GAIN_W-1:0]  gain_code_q;
	logic [TIME_W-1:0]  time_code_q;

	logic [COUNT_W-1:0] cnt_a_q;
	logic [COUNT_W-1:0] cnt_b_q;
	logic [COUNT_W-1:0] cnt_c_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [GAIN_W-1:0]  ng_q;
	logic [TIME_W-1:0]  nt_q;
	logic               chg_q;
	logic [IRR_W-1:0]   irr_a_q;
	logic [IRR_W-1:0]   irr_b_q;
	logic [IRR_W-1:0]   irr_c_q;

	logic               out_valid_q;
	logic [IRR_W-1:0]   o_irr_a_q;
	logic [IRR_W-1:0]   o_irr_b_q;
	logic [IRR_W-1:0]   o_irr_c_q;
	logic [UVI_W-1:0]   o_uvi_q;
	logic [UVI_W-1:0]   uvi_q;
	logic [GAIN_W-1:0]  o_ng_q;
	logic [TIME_W-1:0]  o_nt_q;
	logic               o_chg_q;

	logic               in_xfer;
	logic               out_load;
	logic [COUNT_W-1:0] peak;
	logic [GAIN_W-1:0]  ng;
	logic [TIME_W-1:0]  nt;

	scale_ctl_t         scale_ctl;
	logic [COUNT_W-1:0] mul_count;
	logic [COEF_W-1:0]  mul_coef;
	logic [IRR_W-1:0]   scaled;

	div_ctl_t           div_ctl;
	div_sts_t           div_sts;
	logic [SUM_W-1:0]   uv_sum;
	logic [DVD_W-1:0]   quotient;

	assign in_xfer  = samples.valid && samples.ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	// range decision from the peak channel; bright takes precedence
	always_comb begin
		peak = samples.count_a;
		if (samples.count_b > peak) begin
			peak = samples.count_b;
		end
		if (samples.count_c > peak) begin
			peak = samples.count_c;
		end
		ng = gain_code_q;
		nt = time_code_q;
		if (peak > bright_q) begin
			if (time_code_q != '0) begin
				nt = time_code_q - 1'b1;
			end else if (gain_code_q < GAIN_MAX) begin
				ng = gain_code_q + 1'b1;
			end
		end else if (peak < dark_q) begin
			if (gain_code_q != '0) begin
				ng = gain_code_q - 1'b1;
			end else if (time_code_q < TIME_MAX) begin
				nt = time_code_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				if (ch_q == 2'd3) begin
					state_nx = ST_SUM;
				end
			end
			ST_SUM: state_nx = ST_DIV;
			ST_DIV: begin
				if (div_sts.done) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready    = 1'b0;
		scale_ctl.mul_en = 1'b0;
		scale_ctl.shift  = shift_q;
		div_ctl.start    = 1'b0;
		case (state_q)
			ST_IDLE: samples.ready    = 1'b1;
			ST_MUL:  scale_ctl.mul_en = (ch_q != 2'd3);
			ST_SUM:  div_ctl.start    = 1'b1;
			default: begin
			end
		endcase
	end

	always_comb begin
		case (ch_q)
			2'd0: begin
				mul_count = cnt_a_q;
				mul_coef  = coef_a_q;
			end
			2'd1: begin
				mul_count = cnt_b_q;
				mul_coef  = coef_b_q;
			end
			default: begin
				mul_count = cnt_c_q;
				mul_coef  = coef_c_q;
			end
		endcase
	end

	// 4000*irr_b + 8*irr_a
	assign uv_sum = {irr_b_q, 12'b0} - {6'b0, irr_b_q, 6'b0} - {7'b0, irr_b_q, 5'b0}
		+ {9'b0, irr_a_q, 3'b0};

	uvas_scale_unit u_scale (
		.clk   (clk),
		.ctl   (scale_ctl),
		.count (mul_count),
		.coef  (mul_coef),
		.irr   (scaled)
	);

	uvas_div100 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (uv_sum),
		.sts      (div_sts),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			bright_q    <= 16'd60000;
			dark_q      <= 16'd200;
			coef_a_q    <= 24'd1089372;
			coef_b_q    <= 24'd1204706;
			coef_c_q    <= 24'd131959;
			gain_code_q <= '0;
			time_code_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_MUL) begin
				ch_q <= ch_q + 1'b1;
			end else begin
				ch_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer) begin
				gain_code_q <= ng;
				time_code_q <= nt;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BRIGHT_LIMIT: bright_q <= cfg_data[COUNT_W-1:0];
					REG_DARK_LIMIT:   dark_q   <= cfg_data[COUNT_W-1:0];
					REG_START_GAIN: begin
						if (cfg_data[GAIN_W-1:0] > GAIN_MAX) begin
							gain_code_q <= GAIN_MAX;
						end else begin
							gain_code_q <= cfg_data[GAIN_W-1:0];
						end
					end
					REG_START_TIME: begin
						if (cfg_data[TIME_W-1:0] > TIME_MAX) begin
							time_code_q <= TIME_MAX;
						end else begin
							time_code_q <= cfg_data[TIME_W-1:0];
						end
					end
					REG_COEF_A: coef_a_q <= cfg_data;
					REG_COEF_B: coef_b_q <= cfg_data;
					REG_COEF_C: coef_c_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cnt_a_q <= samples.count_a;
			cnt_b_q <= samples.count_b;
			cnt_c_q <= samples.count_c;
			shift_q <= SHIFT_W'(GAIN_MAX) - SHIFT_W'(gain_code_q) + SHIFT_W'(time_code_q);
			ng_q    <= ng;
			nt_q    <= nt;
			chg_q   <= (ng != gain_code_q) || (nt != time_code_q);
		end
		if (state_q == ST_MUL) begin
			case (ch_q)
				2'd1:    irr_a_q <= scaled;
				2'd2:    irr_b_q <= scaled;
				2'd3:    irr_c_q <= scaled;
				default: begin
				end
			endcase
		end
		if (state_q == ST_DIV && div_sts.done) begin
			uvi_q <= quotient[UVI_W-1:0];
		end
		if (out_load) begin
			o_irr_a_q <= irr_a_q;
			o_irr_b_q <= irr_b_q;
			o_irr_c_q <= irr_c_q;
			o_uvi_q   <= uvi_q;
			o_ng_q    <= ng_q;
			o_nt_q    <= nt_q;
			o_chg_q   <= chg_q;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.irr_a           = o_irr_a_q;
	assign results.irr_b           = o_irr_b_q;
	assign results.irr_c           = o_irr_c_q;
	assign results.uv_level        = o_uvi_q;
	assign results.next_gain       = o_ng_q;
	assign results.next_time       = o_nt_q;
	assign results.setting_changed = o_chg_q;
	assign results.control_byte    = {o_ng_q, 1'b0, o_nt_q};

	a_codes_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_code_q <= GAIN_MAX) && (time_code_q <= TIME_MAX))
		else $error("gain or time code out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !samples.ready)
		else $error("sample accepted while a sample is in flight");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide phase");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy)
		else $error("divider restarted while busy");

endmodule

[rtl/uvas_scale_unit.sv]
// Shared 16x24 multiplier with a registered product, then right shift and 40-bit saturation.
// Depends on uvas_pkg.
module uvas_scale_unit (
	input  logic                         clk,
	input  uvas_pkg::scale_ctl_t         ctl,
	input  logic [uvas_pkg::COUNT_W-1:0] count,
	input  logic [uvas_pkg::COEF_W-1:0]  coef,
	output logic [uvas_pkg::IRR_W-1:0]   irr
);
	import uvas_pkg::*;

	logic [PROD_W-1:0]   prod_s1;
	logic [PROD_W+3:0]   shifted;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= PROD_W'(count) * PROD_W'(coef);
		end
	end

	// Q28.12 product to Q24.16, then drop the range bits
	assign shifted = {prod_s1, 4'b0000} >> ctl.shift;

	always_comb begin
		if (shifted[PROD_W+3:IRR_W] != '0) begin
			irr = '1;
		end else begin
			irr = shifted[IRR_W-1:0];
		end
	end

endmodule

[rtl/uvas_div100.sv]
// Iterative restoring divider by one hundred, eight quotient bits per cycle.
// Depends on uvas_pkg.
module uvas_div100 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  uvas_pkg::div_ctl_t          ctl,
	input  logic [uvas_pkg::SUM_W-1:0]  dividend,
	output uvas_pkg::div_sts_t          sts,
	output logic [uvas_pkg::DVD_W-1:0]  quotient
);
	import uvas_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [RND_W-1:0] rnd_q;
	logic             busy_q;
	logic             done_q;
	logic [DVD_W-1:0] dvd_nx;
	logic [REM_W-1:0] rem_nx;

	always_comb begin
		logic [REM_W:0]   r;
		logic [DVD_W-1:0] d;
		r = {1'b0, rem_q};
		d = dvd_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[REM_W-1:0], d[DVD_W-1]};
			d = {d[DVD_W-2:0], 1'b0};
			if (r >= (REM_W+1)'(DIVISOR)) begin
				r = r - (REM_W+1)'(DIVISOR);
				d[0] = 1'b1;
			end
		end
		dvd_nx = d;
		rem_nx = r[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == RND_W'(DIV_ROUNDS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= {{(DVD_W-SUM_W){1'b0}}, dividend};
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dvd_q;

endmodule

[bench/tb_uv_sensor_autorange_scaler_core.sv]
// Self-checking bench for uv_sensor_autorange_scaler_core: directed table, then random phases.
// Scaling, UV index and auto-range codes are predicted per sample transfer and checked in order.
// Depends on uvas_pkg, uvas_if and the core RTL.
`timescale 1ns / 1ps

module tb_uv_sensor_autorange_scaler_core;
	import uvas_pkg::*;

	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SETTLE_CYCLES   = 32;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 50;

	localparam logic [15:0] DEF_BRIGHT = 16'd60000;
	localparam logic [15:0] DEF_DARK   = 16'd200;
	localparam logic [23:0] DEF_COEF_A = 24'd1089372;
	localparam logic [23:0] DEF_COEF_B = 24'd1204706;
	localparam logic [23:0] DEF_COEF_C = 24'd131959;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam logic [63:0] IRR_SAT = (64'd1 << IRR_W) - 64'd1;
	localparam logic [63:0] UVI_SAT = (64'd1 << UVI_W) - 64'd1;

	typedef struct {
		logic [IRR_W-1:0]  irr_a;
		logic [IRR_W-1:0]  irr_b;
		logic [IRR_W-1:0]  irr_c;
		logic [UVI_W-1:0]  uv_level;
		logic [GAIN_W-1:0] next_gain;
		logic [TIME_W-1:0] next_time;
		logic              setting_changed;
		logic [CTRL_W-1:0] control_byte;
	} uv_result_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [COUNT_W-1:0]    a;
		logic [COUNT_W-1:0]    b;
		logic [COUNT_W-1:0]    c;
		bit                    typed;
		uv_result_t            res;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	uvas_in_if  smp ();
	uvas_out_if res ();

	uv_sensor_autorange_scaler_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp),
		.results   (res),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [15:0]       shadow_bright;
	logic [15:0]       shadow_dark;
	logic [GAIN_W-1:0] shadow_start_gain;
	logic [TIME_W-1:0] shadow_start_time;
	logic [23:0]       shadow_coef_a;
	logic [23:0]       shadow_coef_b;
	logic [23:0]       shadow_coef_c;
	logic [GAIN_W-1:0] shadow_gain;
	logic [TIME_W-1:0] shadow_time;

	uv_result_t expected_q[$];
	step_row_t  plan[$];
	int         mismatches;
	int         quiet_cycles;
	bit         no_idle;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [IRR_W-1:0] scale_count_q16(logic [COUNT_W-1:0] cnt,
		logic [COEF_W-1:0] k, int unsigned sh);
		logic [63:0] v;
		v = (64'(cnt) * 64'(k)) << 4;
		v = v >> sh;
		if (v > IRR_SAT)
			v = IRR_SAT;
		return v[IRR_W-1:0];
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_BRIGHT_LIMIT: shadow_bright = data[15:0];
			REG_DARK_LIMIT:   shadow_dark = data[15:0];
			REG_START_GAIN: begin
				shadow_start_gain = data[GAIN_W-1:0];
				shadow_gain = (shadow_start_gain > GAIN_MAX) ? GAIN_MAX : shadow_start_gain;
			end
			REG_START_TIME: begin
				shadow_start_time = data[TIME_W-1:0];
				shadow_time = (shadow_start_time > TIME_MAX) ? TIME_MAX : shadow_start_time;
			end
			REG_COEF_A: shadow_coef_a = data[23:0];
			REG_COEF_B: shadow_coef_b = data[23:0];
			REG_COEF_C: shadow_coef_c = data[23:0];
			default: ;
		endcase
	endtask

	task automatic predict_sample(input logic [COUNT_W-1:0] a, b, c, output uv_result_t r);
		logic [GAIN_W-1:0]  g;
		logic [GAIN_W-1:0]  ng;
		logic [TIME_W-1:0]  t;
		logic [TIME_W-1:0]  nt;
		logic [COUNT_W-1:0] peak;
		logic [63:0]        weighted;
		int unsigned        sh;
		g = (shadow_gain > GAIN_MAX) ? GAIN_MAX : shadow_gain;
		t = (shadow_time > TIME_MAX) ? TIME_MAX : shadow_time;
		sh = (GAIN_CODES - 1) - int'(g) + int'(t);
		r.irr_a = scale_count_q16(a, shadow_coef_a, sh);
		r.irr_b = scale_count_q16(b, shadow_coef_b, sh);
		r.irr_c = scale_count_q16(c, shadow_coef_c, sh);
		weighted = (64'(r.irr_b) * 64'd4000 + 64'(r.irr_a) * 64'd8) / 64'd100;
		if (weighted > UVI_SAT)
			weighted = UVI_SAT;
		r.uv_level = weighted[UVI_W-1:0];
		peak = a;
		if (b > peak)
			peak = b;
		if (c > peak)
			peak = c;
		ng = g;
		nt = t;
		if (peak > shadow_bright) begin
			if (nt != '0)
				nt = nt - 1'b1;
			else if (ng < GAIN_MAX)
				ng = ng + 1'b1;
		end else if (peak < shadow_dark) begin
			if (ng != '0)
				ng = ng - 1'b1;
			else if (nt < TIME_MAX)
				nt = nt + 1'b1;
		end
		r.next_gain = ng;
		r.next_time = nt;
		r.setting_changed = (ng != g) || (nt != t);
		r.control_byte = {ng, 1'b0, nt};
		shadow_gain = ng;
		shadow_time = nt;
	endtask

	function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		step_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	function automatic step_row_t smp_row(logic [COUNT_W-1:0] a, b, c);
		step_row_t row;
		row = '{default: '0};
		row.a = a;
		row.b = b;
		row.c = c;
		return row;
	endfunction

	// all typed rows have zero irradiance: zero counts or zero coefficients
	function automatic step_row_t zero_irr_row(logic [COUNT_W-1:0] a, b, c,
		logic [GAIN_W-1:0] ng, logic [TIME_W-1:0] nt, logic chg, logic [CTRL_W-1:0] ctrl);
		step_row_t row;
		row = smp_row(a, b, c);
		row.typed = 1'b1;
		row.res.irr_a = '0;
		row.res.irr_b = '0;
		row.res.irr_c = '0;
		row.res.uv_level = '0;
		row.res.next_gain = ng;
		row.res.next_time = nt;
		row.res.setting_changed = chg;
		row.res.control_byte = ctrl;
		return row;
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count(int mode);
		int v;
		case (mode)
			0: v = int'(shadow_bright) + int'($urandom_range(0, 40)) - 20;
			1: v = int'(shadow_dark) + int'($urandom_range(0, 40)) - 20;
			2: v = $urandom_range(0, 255);
			3: v = $urandom_range(0, 1) ? 65535 : 0;
			default: v = $urandom_range(0, 65535);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[COUNT_W-1:0];
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic send_sample(input logic [COUNT_W-1:0] a, b, c, input bit typed,
		input uv_result_t fixed);
		int gap;
		uv_result_t r;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		cfg_wr_en <= 1'b0;
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.count_a <= a;
		smp.count_b <= b;
		smp.count_c <= c;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		predict_sample(a, b, c, r);
		if (typed)
			expected_q.push_back(fixed);
		else
			expected_q.push_back(r);
	endtask

	task automatic drain_results();
		smp.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	// result side: random stall per result unless no_idle is set, in-order check against the expected store
	initial begin
		int stall;
		uv_result_t seen;
		uv_result_t want;
		res.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
			seen.irr_a = res.irr_a;
			seen.irr_b = res.irr_b;
			seen.irr_c = res.irr_c;
			seen.uv_level = res.uv_level;
			seen.next_gain = res.next_gain;
			seen.next_time = res.next_time;
			seen.setting_changed = res.setting_changed;
			seen.control_byte = res.control_byte;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result transfer with nothing expected: irr_a %h uv_level %h",
						seen.irr_a, seen.uv_level);
			end else begin
				want = expected_q.pop_front();
				check_field("irr_a", 64'(want.irr_a), 64'(seen.irr_a));
				check_field("irr_b", 64'(want.irr_b), 64'(seen.irr_b));
				check_field("irr_c", 64'(want.irr_c), 64'(seen.irr_c));
				check_field("uv_level", 64'(want.uv_level), 64'(seen.uv_level));
				check_field("next_gain", 64'(want.next_gain), 64'(seen.next_gain));
				check_field("next_time", 64'(want.next_time), 64'(seen.next_time));
				check_field("setting_changed", 64'(want.setting_changed),
					64'(seen.setting_changed));
				check_field("control_byte", 64'(want.control_byte), 64'(seen.control_byte));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (smp.valid && smp.ready) || (res.valid && res.ready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		bit prev_cfg;
		int mode;
		uv_result_t blank;
		logic [15:0] bl;
		logic [15:0] dl;
		logic [3:0]  sg;
		logic [2:0]  st;
		logic [23:0] ka;
		logic [23:0] kb;
		logic [23:0] kc;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		smp.valid = 1'b0;
		smp.count_a = '0;
		smp.count_b = '0;
		smp.count_c = '0;
		no_idle = 1'b0;
		blank = '{default: '0};

		shadow_bright = DEF_BRIGHT;
		shadow_dark = DEF_DARK;
		shadow_start_gain = '0;
		shadow_start_time = '0;
		shadow_coef_a = DEF_COEF_A;
		shadow_coef_b = DEF_COEF_B;
		shadow_coef_c = DEF_COEF_C;
		shadow_gain = '0;
		shadow_time = '0;

		plan.push_back(zero_irr_row(16'h0000, 16'h0000, 16'h0000, 4'd0, 3'd1, 1'b1, 8'h01));
		plan.push_back(cfg_row(REG_COEF_A, 24'h000000));
		plan.push_back(cfg_row(REG_COEF_B, 24'h000000));
		plan.push_back(cfg_row(REG_COEF_C, 24'h000000));
		plan.push_back(zero_irr_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 3'd0, 1'b1, 8'h00));
		plan.push_back(zero_irr_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd1, 3'd0, 1'b1, 8'h10));
		plan.push_back(cfg_row(REG_COEF_A, 24'hFFFFFF));
		plan.push_back(cfg_row(REG_COEF_B, 24'hFFFFFF));
		plan.push_back(cfg_row(REG_COEF_C, 24'hFFFFFF));
		plan.push_back(cfg_row(REG_START_GAIN, 24'd11));
		plan.push_back(cfg_row(REG_START_TIME, 24'd0));
		plan.push_back(smp_row(16'hFFFF, 16'hFFFF, 16'hFFFF));
		plan.push_back(cfg_row(REG_START_GAIN, 24'd15));
		plan.push_back(cfg_row(REG_START_TIME, 24'd7));
		plan.push_back(smp_row(16'h0000, 16'h0000, 16'h0000));
		plan.push_back(cfg_row(REG_START_GAIN, 24'd0));
		plan.push_back(smp_row(16'h0000, 16'h0000, 16'h0001));
		plan.push_back(cfg_row(REG_BRIGHT_LIMIT, 24'h000000));
		plan.push_back(cfg_row(REG_DARK_LIMIT, 24'h00FFFF));
		plan.push_back(smp_row(16'd100, 16'd5, 16'd7));
		plan.push_back(cfg_row(REG_BRIGHT_LIMIT, 24'd1000));
		plan.push_back(cfg_row(REG_DARK_LIMIT, 24'd1000));
		plan.push_back(smp_row(16'd1000, 16'd999, 16'd0));
		plan.push_back(cfg_row(REG_SPARE, 24'hFFFFFF));
		plan.push_back(cfg_row(REG_BRIGHT_LIMIT, 24'(DEF_BRIGHT)));
		plan.push_back(cfg_row(REG_DARK_LIMIT, 24'(DEF_DARK)));
		plan.push_back(cfg_row(REG_COEF_A, DEF_COEF_A));
		plan.push_back(cfg_row(REG_COEF_B, DEF_COEF_B));
		plan.push_back(cfg_row(REG_COEF_C, DEF_COEF_C));
		plan.push_back(smp_row(16'd12345, 16'd54321, 16'd777));
		plan.push_back(smp_row(16'd1, 16'd2, 16'd3));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		prev_cfg = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (!prev_cfg)
					drain_results();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_sample(plan[i].a, plan[i].b, plan[i].c, plan[i].typed, plan[i].res);
			end
			prev_cfg = plan[i].is_cfg;
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			no_idle = (ph % 4 == 3);
			if (ph == 0) begin
				bl = 16'hFFFF;
				dl = 16'h0000;
				sg = 4'd15;
				st = 3'd7;
				ka = 24'hFFFFFF;
				kb = 24'hFFFFFF;
				kc = 24'hFFFFFF;
			end else if (ph == 1) begin
				bl = 16'h0000;
				dl = 16'hFFFF;
				sg = 4'd0;
				st = 3'd0;
				ka = 24'h000000;
				kb = 24'h000000;
				kc = 24'h000000;
			end else begin
				dl = 16'($urandom_range(0, 4000));
				bl = 16'($urandom_range(int'(dl), 65535));
				sg = 4'($urandom_range(0, 15));
				st = 3'($urandom_range(0, 7));
				ka = 24'($urandom());
				kb = 24'($urandom());
				kc = 24'($urandom());
			end
			write_reg(REG_BRIGHT_LIMIT, 24'(bl));
			write_reg(REG_DARK_LIMIT, 24'(dl));
			write_reg(REG_START_GAIN, 24'(sg));
			write_reg(REG_START_TIME, 24'(st));
			write_reg(REG_COEF_A, ka);
			write_reg(REG_COEF_B, kb);
			write_reg(REG_COEF_C, kc);
			repeat (ITEMS_PER_PHASE) begin
				mode = $urandom_range(0, 7);
				send_sample(pick_count(mode), pick_count(mode), pick_count(mode), 1'b0, blank);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/uvas_pkg.sv
rtl/uvas_if.sv
rtl/uvas_scale_unit.sv
rtl/uvas_div100.sv
rtl/uv_sensor_autorange_scaler_core.sv
bench/tb_uv_sensor_autorange_scaler_core.sv
